/* rtl/trd_pkg.sv */
package trd_pkg;

  // screen and store geometry
  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam int DIM_W   = 10;
  localparam int PIX_W   = 9;
  localparam int DEPTH_W = 16;

  localparam logic [DEPTH_W-1:0] DEPTH_FAR = '1;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // vertex select codes
  localparam logic [1:0] VSEL_V2   = 2'd2;
  localparam logic [1:0] VSEL_NONE = 2'd3;

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [1:0]         vertex_sel;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic [15:0]        vert_depth;
  } cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pix_x;
    logic [PIX_W-1:0]   pix_y;
    logic               covered;
    logic               visible;
    logic [15:0]        bary_a;
    logic [15:0]        bary_b;
    logic [15:0]        bary_g;
    logic [DEPTH_W-1:0] frag_depth;
    logic               last;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BOX,
    ST_E_MUL,
    ST_E_ACC,
    ST_NORM,
    ST_DIV,
    ST_COV,
    ST_W_MUL,
    ST_W_ACC,
    ST_Z_MUL,
    ST_Z_ACC,
    ST_Z_FIN,
    ST_RD,
    ST_CMP,
    ST_OUT
  } state_t;

endpackage

/* rtl/trd_stream_if.sv */
interface trd_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/trd_recip_div.sv */
module trd_recip_div
  import trd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  // shift in one dividend bit (all low bits are ones)
  assign trial = {rem, 1'b1};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 32'h7FFF_FFFF;
      quo <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= 32'(trial - {1'b0, dvs});
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

/* rtl/trd_depth_store.sv */
module trd_depth_store
  import trd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [STORE_AW-1:0] rd_addr,
  output logic [DEPTH_W-1:0]  rd_data,
  input  logic                wr_en,
  input  logic [STORE_AW-1:0] wr_addr,
  input  logic [DEPTH_W-1:0]  wr_data,
  output logic                ready
);

  logic [DEPTH_W-1:0]  mem [STORE_DEPTH];
  logic                clr_busy;
  logic [STORE_AW-1:0] clr_addr;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == STORE_AW'(STORE_DEPTH - 1)) clr_busy <= 1'b0;
    end
  end

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (clr_busy) mem[clr_addr] <= DEPTH_FAR;
    else if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign ready = !clr_busy;

endmodule

/* rtl/triangle_raster_depth_test.sv */
// Loading vertex 2 holds the input for setup, which ends once the area term is found
// zero and else goes on through normalization and the divider. A pixel step runs the
// edge pass; a covered pixel adds weights and depth and, on screen, the store read and
// compare; the result then waits while the output register is still full, and the
// next item can be taken in the cycle after it loads. One shared edge multiplier and
// one weight/depth multiplier are used in turn. Reset is synchronous; afterwards the
// depth store is cleared one entry a cycle over all 262144 entries, during which no item is
// taken (register writes still are).
module triangle_raster_depth_test
  import trd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  trd_stream_if.sink         cmd,
  trd_stream_if.source       res,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [DIM_W-1:0]   cfg_data
);

  state_t state, state_next;

  // configuration
  logic [DIM_W-1:0] width_reg, height_reg, eff_w, eff_h;

  // triangle state
  logic signed [15:0] vx [3];
  logic signed [15:0] vy [3];
  logic [15:0]        vz [3];
  logic [31:0]        recip;
  logic [6:0]         norm;
  logic               area_neg;
  logic [PIX_W-1:0]   box_xl, box_xh, box_yl, box_yh;
  logic [PIX_W-1:0]   cur_x, cur_y;
  logic               walk;

  // per-item working registers
  logic [PIX_W-1:0]   wx, wy;
  logic               wlast, setup, ph, vis, cov_r;
  logic [1:0]         k;
  logic signed [39:0] acc;
  logic signed [39:0] e [3];
  logic [39:0]        dmag, cnt_tmp;
  logic signed [37:0] eprod;
  logic [63:0]        uprod;
  logic [15:0]        wt [3];
  logic [33:0]        zsum;
  logic [15:0]        zval;
  logic [STORE_AW-1:0] idx;

  // output register
  res_t res_reg;
  logic res_valid;

  // sub-units
  logic        div_start, div_done;
  logic [31:0] div_q, div_d;
  logic        store_rd, store_we, store_ready;
  logic [DEPTH_W-1:0] store_q;

  logic cmd_xfer, res_load;

  function automatic logic [31:0] norm32(input logic [39:0] m, input logic [6:0] n);
    logic [63:0] wide;
    wide = {24'b0, m};
    if (n <= 7'd32) wide = wide << (7'd32 - n);
    else wide = wide >> (n - 7'd32);
    return wide[31:0];
  endfunction

  function automatic logic [39:0] mag40(input logic signed [39:0] v);
    return v[39] ? 40'(-v) : 40'(v);
  endfunction

  function automatic logic signed [17:0] dbl(input logic signed [15:0] v);
    return {{1{v[15]}}, v, 1'b0};
  endfunction

  // effective screen size
  always_comb begin
    eff_w = width_reg;
    if (width_reg == '0) eff_w = DIM_W'(1);
    else if (width_reg > DIM_W'(MAX_WIDTH)) eff_w = DIM_W'(MAX_WIDTH);
    eff_h = height_reg;
    if (height_reg == '0) eff_h = DIM_W'(1);
    else if (height_reg > DIM_W'(MAX_HEIGHT)) eff_h = DIM_W'(MAX_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= DIM_W'(512);
      height_reg <= DIM_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_reg  <= cfg_data;
        REG_HEIGHT: height_reg <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign cmd.ready = (state == ST_IDLE) && store_ready;
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign res_load  = (state == ST_OUT) && (!res_valid || res.ready);

  // bounding box
  logic signed [17:0] mnx, mxx, mny, mxy, lx, hx, ly, hy;
  logic signed [17:0] wm1, hm1;
  always_comb begin
    mnx = 18'(vx[0]); mxx = 18'(vx[0]);
    mny = 18'(vy[0]); mxy = 18'(vy[0]);
    for (int i = 1; i < 3; i++) begin
      if (18'(vx[i]) < mnx) mnx = 18'(vx[i]);
      if (18'(vx[i]) > mxx) mxx = 18'(vx[i]);
      if (18'(vy[i]) < mny) mny = 18'(vy[i]);
      if (18'(vy[i]) > mxy) mxy = 18'(vy[i]);
    end
    lx = mnx >>> 4;
    ly = mny >>> 4;
    hx = (mxx + 18'sd15) >>> 4;
    hy = (mxy + 18'sd15) >>> 4;
    wm1 = $signed({8'b0, eff_w}) - 18'sd1;
    hm1 = $signed({8'b0, eff_h}) - 18'sd1;
    if (lx < 0) lx = '0;
    if (ly < 0) ly = '0;
    if (hx > wm1) hx = wm1;
    if (hy > hm1) hy = hm1;
  end

  // edge operand selection
  logic signed [17:0] ax, ay, bx, by, px, py;
  logic signed [18:0] op1, op2;
  always_comb begin
    unique case (k)
      2'd0:    begin ax = dbl(vx[1]); ay = dbl(vy[1]); bx = dbl(vx[2]); by = dbl(vy[2]); end
      2'd1:    begin ax = dbl(vx[2]); ay = dbl(vy[2]); bx = dbl(vx[0]); by = dbl(vy[0]); end
      default: begin ax = dbl(vx[0]); ay = dbl(vy[0]); bx = dbl(vx[1]); by = dbl(vy[1]); end
    endcase
    if (setup) begin
      px = dbl(vx[0]);
      py = dbl(vy[0]);
    end else begin
      px = $signed({4'b0, wx, 1'b1, 4'b0});
      py = $signed({4'b0, wy, 1'b1, 4'b0});
    end
    if (!ph) begin
      op1 = 19'(px) - 19'(ax);
      op2 = 19'(by) - 19'(ay);
    end else begin
      op1 = 19'(py) - 19'(ay);
      op2 = 19'(bx) - 19'(ax);
    end
  end

  logic signed [39:0] eval;
  assign eval = acc - 40'(eprod);

  logic cov;
  always_comb begin
    if (recip == '0) cov = 1'b0;
    else if (area_neg) cov = e[0][39] && e[1][39] && e[2][39];
    else cov = !e[0][39] && e[0] != 0 && !e[1][39] && e[1] != 0
               && !e[2][39] && e[2] != 0;
  end

  logic [33:0] zround;
  assign zround = (zsum + 34'd16384) >> 15;
  assign div_d  = norm32(dmag, norm);
  assign div_start = (state == ST_NORM) && (cnt_tmp == '0);
  assign store_rd  = (state == ST_RD);
  assign store_we  = (state == ST_CMP) && (zval < store_q);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_xfer) begin
          if (cmd.payload.req_type == REQ_LOAD) begin
            if (cmd.payload.vertex_sel == VSEL_V2) state_next = ST_BOX;
          end else if (walk) begin
            state_next = ST_E_MUL;
          end
        end
      end
      ST_BOX:   state_next = ST_E_MUL;
      ST_E_MUL: state_next = ST_E_ACC;
      ST_E_ACC: begin
        if (!ph) state_next = ST_E_MUL;
        else if (setup) state_next = (eval == 0) ? ST_IDLE : ST_NORM;
        else state_next = (k == 2'd2) ? ST_COV : ST_E_MUL;
      end
      ST_NORM:  if (cnt_tmp == '0) state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_IDLE;
      ST_COV:   state_next = cov ? ST_W_MUL : ST_OUT;
      ST_W_MUL: state_next = ST_W_ACC;
      ST_W_ACC: state_next = (k == 2'd2) ? ST_Z_MUL : ST_W_MUL;
      ST_Z_MUL: state_next = ST_Z_ACC;
      ST_Z_ACC: state_next = (k == 2'd2) ? ST_Z_FIN : ST_Z_MUL;
      ST_Z_FIN: begin
        if (wx < eff_w[PIX_W-1:0] || eff_w[DIM_W-1]) begin
          state_next = ((wy < eff_h[PIX_W-1:0]) || eff_h[DIM_W-1]) ? ST_RD : ST_OUT;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_RD:    state_next = ST_CMP;
      ST_CMP:   state_next = ST_OUT;
      ST_OUT:   if (res_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // triangle and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        vx[i] <= '0; vy[i] <= '0; vz[i] <= '0;
      end
      recip <= '0; norm <= '0; area_neg <= 1'b0;
      box_xl <= '0; box_xh <= '0; box_yl <= '0; box_yh <= '0;
      cur_x <= '0; cur_y <= '0;
      walk <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_xfer && cmd.payload.req_type == REQ_LOAD) begin
            if (cmd.payload.vertex_sel != VSEL_NONE) begin
              vx[cmd.payload.vertex_sel] <= cmd.payload.vert_x;
              vy[cmd.payload.vertex_sel] <= cmd.payload.vert_y;
              vz[cmd.payload.vertex_sel] <= cmd.payload.vert_depth;
              walk <= 1'b0;
            end
          end else if (cmd_xfer && walk) begin
            // advance the cursor, y fastest
            if (cur_x == box_xh && cur_y == box_yh) begin
              walk <= 1'b0;
            end else if (cur_y >= box_yh) begin
              cur_y <= box_yl;
              cur_x <= cur_x + 1'b1;
            end else begin
              cur_y <= cur_y + 1'b1;
            end
          end
        end
        ST_BOX: begin
          box_xl <= lx[PIX_W-1:0]; box_xh <= hx[PIX_W-1:0];
          box_yl <= ly[PIX_W-1:0]; box_yh <= hy[PIX_W-1:0];
          cur_x  <= lx[PIX_W-1:0]; cur_y  <= ly[PIX_W-1:0];
          walk   <= (lx <= hx) && (ly <= hy);
        end
        ST_E_ACC: begin
          if (ph && setup) begin
            area_neg <= eval[39];
            recip    <= '0;
            norm     <= '0;
          end
        end
        ST_NORM: if (cnt_tmp != '0) norm <= norm + 7'd1;
        ST_DIV:  if (div_done) recip <= div_q;
        default: ;
      endcase
    end
  end

  // per-item datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        wx    <= cur_x;
        wy    <= cur_y;
        wlast <= (cur_x == box_xh) && (cur_y == box_yh);
        setup <= 1'b0;
        k     <= '0;
        ph    <= 1'b0;
      end
      ST_BOX: begin
        setup <= 1'b1;
        k     <= '0;
        ph    <= 1'b0;
      end
      ST_E_MUL: eprod <= op1 * op2;
      ST_E_ACC: begin
        ph <= !ph;
        if (!ph) begin
          acc <= 40'(eprod);
        end else if (setup) begin
          dmag    <= mag40(eval);
          cnt_tmp <= mag40(eval);
        end else begin
          e[k] <= eval;
          k    <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        end
      end
      ST_NORM: cnt_tmp <= cnt_tmp >> 1;
      ST_COV: begin
        cov_r <= cov;
        vis   <= 1'b0;
        zsum  <= '0;
        k     <= '0;
        if (!cov) begin
          for (int i = 0; i < 3; i++) wt[i] <= '0;
          zval <= '0;
        end
      end
      ST_W_MUL: uprod <= {32'b0, norm32(mag40(e[k]), norm)} * {32'b0, recip};
      ST_W_ACC: begin
        wt[k] <= (uprod[63:48] > 16'd32768) ? 16'd32768 : uprod[63:48];
        k     <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end
      ST_Z_MUL: uprod <= {48'b0, wt[k]} * {48'b0, vz[k]};
      ST_Z_ACC: begin
        zsum <= zsum + uprod[33:0];
        k    <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end
      ST_Z_FIN: begin
        zval <= (zround > 34'(DEPTH_FAR)) ? DEPTH_FAR : zround[DEPTH_W-1:0];
        idx  <= STORE_AW'(eff_h - DIM_W'(1) - {1'b0, wy}) * STORE_AW'(eff_w)
                + STORE_AW'(wx);
      end
      ST_CMP: vis <= store_we;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (res_load) res_valid <= 1'b1;
    else if (res.ready) res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_reg.pix_x      <= wx;
      res_reg.pix_y      <= wy;
      res_reg.covered    <= cov_r;
      res_reg.visible    <= vis;
      res_reg.bary_a     <= wt[0];
      res_reg.bary_b     <= wt[1];
      res_reg.bary_g     <= wt[2];
      res_reg.frag_depth <= zval;
      res_reg.last       <= wlast;
    end
  end

  assign res.valid   = res_valid;
  assign res.payload = res_reg;

  trd_recip_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  trd_depth_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (store_rd),
    .rd_addr (idx),
    .rd_data (store_q),
    .wr_en   (store_we),
    .wr_addr (idx),
    .wr_data (zval),
    .ready   (store_ready)
  );

  // checks
  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> store_ready)
    else $error("item taken during store clear");

  a_visible_needs_cover: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!res.payload.visible || res.payload.covered))
    else $error("visible pixel not covered");

  a_uncovered_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.payload.covered) |->
      (res.payload.bary_a == 16'd0 && res.payload.frag_depth == '0))
    else $error("uncovered pixel carries weights");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside setup");

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    store_we |-> $past(state) == ST_RD)
    else $error("store write without read");

endmodule

/* tb/triangle_raster_depth_test_test.sv */
module triangle_raster_depth_test_test;
  import trd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int RANDOM_ITEMS   = 1150;

  typedef struct {
    cmd_t c;
    bit   typed;
    res_t r;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [DIM_W-1:0] cfg_data;

  trd_stream_if #(.payload_t(cmd_t)) cmd_ch ();
  trd_stream_if #(.payload_t(res_t)) res_ch ();

  triangle_raster_depth_test dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic signed [15:0] vtx_x [3];
  logic signed [15:0] vtx_y [3];
  logic [15:0]        vtx_z [3];
  logic [31:0]        recip;
  int                 norm_bits;
  bit                 area_neg;
  int                 box_lx, box_hx, box_ly, box_hy;
  int                 cur_x, cur_y;
  bit                 walking;
  logic [15:0]        zbuf [int];

  res_t expected_pixels [$];
  int   mismatch_count;
  bit   long_hold;
  bit   send_burst;
  bit   recv_burst;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_dim(logic [DIM_W-1:0] r, int maxv);
    if (r == 0) return 1;
    if (r > maxv) return maxv;
    return int'(r);
  endfunction

  function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                      longint px, longint py);
    return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
  endfunction

  function automatic longint unsigned norm_shift(longint unsigned m);
    if (norm_bits <= 32) return m << (32 - norm_bits);
    return m >> (norm_bits - 32);
  endfunction

  function automatic logic [15:0] bary_weight(longint e);
    longint unsigned m;
    longint unsigned w;
    m = (e < 0) ? longint'(-e) : longint'(e);
    w = (norm_shift(m) * longint'(recip)) >> 48;
    return (w > 32768) ? 16'd32768 : w[15:0];
  endfunction

  // triangle setup on vertex 2
  function automatic void triangle_setup();
    longint x [3];
    longint y [3];
    longint d, m;
    int w, h, mnx, mxx, mny, mxy;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    for (int i = 0; i < 3; i++) begin
      x[i] = 2 * longint'(vtx_x[i]);
      y[i] = 2 * longint'(vtx_y[i]);
    end
    d = edge_val(x[1], y[1], x[2], y[2], x[0], y[0]);
    area_neg = d < 0;
    recip = 0;
    norm_bits = 0;
    if (d != 0) begin
      m = (d < 0) ? -d : d;
      while (norm_bits < 64 && (m >> norm_bits) != 0) norm_bits++;
      recip = 32'(64'h7FFF_FFFF_FFFF_FFFF / norm_shift(m));
    end
    mnx = vtx_x[0]; mxx = vtx_x[0]; mny = vtx_y[0]; mxy = vtx_y[0];
    for (int i = 1; i < 3; i++) begin
      if (vtx_x[i] < mnx) mnx = vtx_x[i];
      if (vtx_x[i] > mxx) mxx = vtx_x[i];
      if (vtx_y[i] < mny) mny = vtx_y[i];
      if (vtx_y[i] > mxy) mxy = vtx_y[i];
    end
    box_lx = mnx >>> 4;
    box_hx = -((-mxx) >>> 4);
    box_ly = mny >>> 4;
    box_hy = -((-mxy) >>> 4);
    if (box_lx < 0) box_lx = 0;
    if (box_ly < 0) box_ly = 0;
    if (box_hx > w - 1) box_hx = w - 1;
    if (box_hy > h - 1) box_hy = h - 1;
    cur_x = box_lx;
    cur_y = box_ly;
    walking = (box_lx <= box_hx) && (box_ly <= box_hy);
  endfunction

  // one accepted command through the predictor
  function automatic bit raster_step(cmd_t c, output res_t r);
    longint x [3];
    longint y [3];
    longint px, py, e0, e1, e2;
    longint unsigned s;
    int w, h, idx;
    bit cov;
    r = '0;
    if (c.req_type == REQ_LOAD) begin
      if (c.vertex_sel != VSEL_NONE) begin
        vtx_x[c.vertex_sel] = c.vert_x;
        vtx_y[c.vertex_sel] = c.vert_y;
        vtx_z[c.vertex_sel] = c.vert_depth;
        walking = 0;
        if (c.vertex_sel == VSEL_V2) triangle_setup();
      end
      return 0;
    end
    if (!walking) return 0;
    for (int i = 0; i < 3; i++) begin
      x[i] = 2 * longint'(vtx_x[i]);
      y[i] = 2 * longint'(vtx_y[i]);
    end
    px = (2 * cur_x + 1) * 16;
    py = (2 * cur_y + 1) * 16;
    e0 = edge_val(x[1], y[1], x[2], y[2], px, py);
    e1 = edge_val(x[2], y[2], x[0], y[0], px, py);
    e2 = edge_val(x[0], y[0], x[1], y[1], px, py);
    if (recip == 0) cov = 0;
    else if (area_neg) cov = e0 < 0 && e1 < 0 && e2 < 0;
    else cov = e0 > 0 && e1 > 0 && e2 > 0;
    if (cov) begin
      r.bary_a = bary_weight(e0);
      r.bary_b = bary_weight(e1);
      r.bary_g = bary_weight(e2);
      s = (longint'(r.bary_a) * vtx_z[0] + longint'(r.bary_b) * vtx_z[1]
           + longint'(r.bary_g) * vtx_z[2] + 16384) >> 15;
      r.frag_depth = (s > 65535) ? DEPTH_FAR : s[15:0];
      w = eff_dim(width_reg, MAX_WIDTH);
      h = eff_dim(height_reg, MAX_HEIGHT);
      if (cur_x < w && cur_y < h) begin
        idx = (h - 1 - cur_y) * w + cur_x;
        if (!zbuf.exists(idx)) zbuf[idx] = DEPTH_FAR;
        if (r.frag_depth < zbuf[idx]) begin
          zbuf[idx] = r.frag_depth;
          r.visible = 1;
        end
      end
    end
    r.pix_x = cur_x;
    r.pix_y = cur_y;
    r.covered = cov;
    r.last = (cur_x == box_hx) && (cur_y == box_hy);
    if (r.last) walking = 0;
    else if (cur_y >= box_hy) begin
      cur_y = box_ly;
      cur_x = cur_x + 1;
    end else cur_y = cur_y + 1;
    return 1;
  endfunction

  function automatic cmd_t mk_cmd(logic rq, logic [1:0] sel, int x, int y, int z);
    cmd_t c;
    c.req_type = rq;
    c.vertex_sel = sel;
    c.vert_x = x;
    c.vert_y = y;
    c.vert_depth = z;
    return c;
  endfunction

  // offer one command, predict at its transfer
  task automatic send_cmd(cmd_t c, bit typed = 0, res_t typed_res = '0);
    int gap;
    res_t r;
    bit taken;
    if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.payload <= c;
    // ready settles between edges, so sample it mid-cycle
    do begin
      @(negedge clk);
      taken = cmd_ch.ready;
      @(posedge clk);
    end while (!taken);
    if (raster_step(c, r)) expected_pixels.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_screen(logic idx, logic [DIM_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) width_reg = v;
    else height_reg = v;
  endtask

  // result side: random stall, then compare each transfer
  initial begin
    res_t got, want;
    int stall;
    bit taken;
    res_ch.ready = 1'b0;
    recv_burst = 0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_burst = ~recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 13);
      if (long_hold) begin
        stall = 600;
        long_hold = 0;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        taken = res_ch.valid;
        got = res_ch.payload;
        @(posedge clk);
      end while (!taken);
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) idle = 0;
      else idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    res_t last_only;
    int cfg_w [6];
    int cfg_h [6];
    int count, phase, steps, bx, by, vz;
    cmd_t tri_cmd [3];

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.payload = '0;
    mismatch_count = 0;
    long_hold = 0;
    send_burst = 0;
    width_reg = 512;
    height_reg = 512;
    for (int i = 0; i < 3; i++) begin
      vtx_x[i] = 0; vtx_y[i] = 0; vtx_z[i] = 0;
    end
    recip = 0; norm_bits = 0; area_neg = 0;
    box_lx = 0; box_hx = 0; box_ly = 0; box_hy = 0;
    cur_x = 0; cur_y = 0; walking = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    last_only = '0;
    last_only.last = 1'b1;
    // step with nothing loaded, ignored load of select 3
    rows.push_back('{mk_cmd(REQ_STEP, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk_cmd(REQ_LOAD, VSEL_NONE, -1, -1, 65535), 0, '0});
    // zero area at origin: one pixel, never covered
    for (int i = 0; i < 3; i++) rows.push_back('{mk_cmd(REQ_LOAD, i, 0, 0, 0), 0, '0});
    rows.push_back('{mk_cmd(REQ_STEP, 0, 0, 0, 0), 1, last_only});
    // box entirely off screen at either extreme
    for (int i = 0; i < 3; i++)
      rows.push_back('{mk_cmd(REQ_LOAD, i, -32768, -32768, 0), 0, '0});
    rows.push_back('{mk_cmd(REQ_STEP, 0, 0, 0, 0), 0, '0});
    for (int i = 0; i < 3; i++)
      rows.push_back('{mk_cmd(REQ_LOAD, i, 32767, 32767, 65535), 0, '0});
    rows.push_back('{mk_cmd(REQ_STEP, 0, 0, 0, 0), 0, '0});
    // small covered triangle walked in full
    rows.push_back('{mk_cmd(REQ_LOAD, 0, 0, 0, 65535), 0, '0});
    rows.push_back('{mk_cmd(REQ_LOAD, 1, 32, 0, 0), 0, '0});
    rows.push_back('{mk_cmd(REQ_LOAD, 2, 0, 32, 30000), 0, '0});
    for (int i = 0; i < 9; i++) rows.push_back('{mk_cmd(REQ_STEP, 0, 0, 0, 0), 0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      send_cmd(row.c, row.typed, row.r);
    end
    wait_drained();

    // random phases over several screen settings
    cfg_w = '{512, 1, 0, 1023, 37, 200};
    cfg_h = '{512, 1, 1023, 0, 300, 9};
    count = 0;
    phase = 0;
    while (count < RANDOM_ITEMS) begin
      if (count >= phase * 160) begin
        wait_drained();
        if (phase < 6) begin
          write_screen(REG_WIDTH, cfg_w[phase]);
          write_screen(REG_HEIGHT, cfg_h[phase]);
        end else begin
          write_screen(REG_WIDTH, $urandom_range(0, 1023));
          write_screen(REG_HEIGHT, $urandom_range(0, 1023));
        end
        if (phase == 3) long_hold = 1;
        phase++;
      end
      if ($urandom_range(0, 7) == 0) begin
        // noise: full-range loads, any select
        for (int i = 0; i < 3; i++) begin
          send_cmd(mk_cmd(REQ_LOAD, $urandom_range(0, 3), $urandom, $urandom, $urandom));
          count++;
        end
      end
      if ($urandom_range(0, 4) != 0 || count < 4) begin
        // well-formed small triangle
        bx = $urandom_range(0, eff_dim(width_reg, MAX_WIDTH) * 16 + 32) - 24;
        by = $urandom_range(0, eff_dim(height_reg, MAX_HEIGHT) * 16 + 32) - 24;
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(0, 5))
            0: vz = 0;
            1: vz = 65535;
            default: vz = $urandom_range(0, 65535);
          endcase
          tri_cmd[i] = mk_cmd(REQ_LOAD, i, bx + $urandom_range(0, 96),
                              by + $urandom_range(0, 96), vz);
        end
      end
      // loads, then a possibly partial walk (repeats test the depth store)
      for (int i = 0; i < 3; i++) begin
        send_cmd(tri_cmd[i]);
        count++;
      end
      steps = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom_range(30, 60);
      for (int i = 0; i < steps; i++) begin
        send_cmd(mk_cmd(REQ_STEP, $urandom, $urandom, $urandom, $urandom));
        count++;
      end
    end

    // drain and finish
    cmd_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
